// ----- rtl/core/morton_tile_address_gen_top_assert.svh -----
// assertion macros for the morton tile address generator
`ifndef MORTON_TILE_ADDRESS_GEN_TOP_ASSERT_SVH
`define MORTON_TILE_ADDRESS_GEN_TOP_ASSERT_SVH

// same-cycle implication, sampled on the rising edge of clk
`define MTAG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on the rising edge of clk
`define MTAG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/mtag_pkg.sv -----
`timescale 1ns / 1ps

package mtag_pkg;

  localparam int TEXEL_BITS    = 6;
  localparam int TILE_SHIFT    = 3;
  localparam int TILE_SIDE     = 8;
  localparam int ADDR_FIELD_W  = 32;
  localparam int DIM_FIELD_W   = 11;
  localparam int BPP_FIELD_W   = 3;
  localparam int CFG_INDEX_W   = 3;
  localparam int CFG_DATA_W    = 32;

  localparam logic [TEXEL_BITS-1:0] TEXEL_LAST = '1;

  localparam logic [BPP_FIELD_W-1:0] BPP_MIN   = 3'd1;
  localparam logic [BPP_FIELD_W-1:0] BPP_MAX   = 3'd4;
  localparam logic [BPP_FIELD_W-1:0] BPP_RESET = 3'd4;

  localparam logic [CFG_INDEX_W-1:0] REG_LINEAR_BASE  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TILED_BASE   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_BYTES  = 3'd4;

  typedef struct packed {
    logic valid;
    logic last;
    logic err;
  } mtag_ctl_t;

endpackage

// ----- rtl/core/mtag_walker.sv -----
`timescale 1ns / 1ps

module mtag_walker #(
  parameter int CLW   = 7,
  parameter int CNT_W = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           restart,
  output logic                           in_stall,
  input  logic                           fmt_err,
  input  logic [CNT_W-1:0]               across,
  input  logic [CNT_W-1:0]               down,
  input  logic                           load,
  output mtag_pkg::mtag_ctl_t            ctl,
  output logic [mtag_pkg::TEXEL_BITS-1:0] pos_texel,
  output logic [CLW-1:0]                 pos_column,
  output logic [CLW-1:0]                 pos_row
);
  import mtag_pkg::*;

  logic [TEXEL_BITS-1:0] texel, texel_next, cur_texel;
  logic [CLW-1:0]        column, column_next, cur_column;
  logic [CLW-1:0]        row, row_next, cur_row;
  logic [CNT_W-1:0]      column_inc, row_inc;
  logic                  accept, is_last;

  assign accept   = in_valid & load;
  assign in_stall = ~load;

  always_comb begin
    cur_texel  = restart ? '0 : texel;
    cur_column = restart ? '0 : column;
    cur_row    = restart ? '0 : row;
    column_inc = CNT_W'(cur_column) + CNT_W'(1);
    row_inc    = CNT_W'(cur_row) + CNT_W'(1);
    is_last    = ~fmt_err && (cur_texel == TEXEL_LAST)
                 && (CNT_W'(cur_column) == across - CNT_W'(1))
                 && (CNT_W'(cur_row) == down - CNT_W'(1));
    texel_next  = cur_texel;
    column_next = cur_column;
    row_next    = cur_row;
    if (!fmt_err) begin
      texel_next = cur_texel + TEXEL_BITS'(1);
      if (cur_texel == TEXEL_LAST) begin
        if (column_inc >= across) begin
          column_next = '0;
          row_next    = (row_inc >= down) ? '0 : row_inc[CLW-1:0];
        end else begin
          column_next = column_inc[CLW-1:0];
        end
      end else begin
        if (CNT_W'(cur_column) >= across) column_next = '0;
        if (CNT_W'(cur_row) >= down) row_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      texel  <= '0;
      column <= '0;
      row    <= '0;
      ctl    <= '0;
    end else begin
      if (load) ctl.valid <= in_valid;
      if (accept) begin
        texel      <= texel_next;
        column     <= column_next;
        row        <= row_next;
        ctl.last   <= is_last;
        ctl.err    <= fmt_err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pos_texel  <= cur_texel;
      pos_column <= cur_column;
      pos_row    <= cur_row;
    end
  end

endmodule

// ----- rtl/core/mtag_index.sv -----
`timescale 1ns / 1ps

module mtag_index #(
  parameter int AW    = 32,
  parameter int CLW   = 7,
  parameter int CNT_W = 8,
  parameter int DW    = 11
) (
  input  logic                           clk,
  input  logic                           rst,
  input  mtag_pkg::mtag_ctl_t            in_ctl,
  input  logic [mtag_pkg::TEXEL_BITS-1:0] pos_texel,
  input  logic [CLW-1:0]                 pos_column,
  input  logic [CLW-1:0]                 pos_row,
  input  logic [CNT_W-1:0]               across,
  input  logic [DW-1:0]                  width_c,
  input  logic [DW-1:0]                  height_c,
  input  logic                           load,
  output logic                           load_up,
  output mtag_pkg::mtag_ctl_t            ctl,
  output logic [AW-1:0]                  tile_off,
  output logic [AW-1:0]                  lin_off
);
  import mtag_pkg::*;

  localparam int TIW = CLW + CNT_W;

  logic [TILE_SHIFT-1:0] x, y;
  logic [TIW-1:0]        tile_idx;
  logic [AW-1:0]         row_from_top, tile_off_next, lin_off_next;

  assign load_up = ~ctl.valid | load;

  // x from even texel bits, y from odd ones
  always_comb begin
    x = {pos_texel[4], pos_texel[2], pos_texel[0]};
    y = {pos_texel[5], pos_texel[3], pos_texel[1]};
    tile_idx      = TIW'(pos_row) * TIW'(across) + TIW'(pos_column);
    tile_off_next = AW'({tile_idx, pos_texel});
    row_from_top  = AW'(height_c) - AW'(1) - AW'({pos_row, y});
    lin_off_next  = AW'(row_from_top * width_c) + AW'({pos_column, x});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (load_up) begin
      ctl <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (load_up && in_ctl.valid) begin
      tile_off <= tile_off_next;
      lin_off  <= lin_off_next;
    end
  end

endmodule

// ----- rtl/core/mtag_scale.sv -----
`timescale 1ns / 1ps

module mtag_scale #(
  parameter int AW = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  mtag_pkg::mtag_ctl_t                in_ctl,
  input  logic [AW-1:0]                      tile_off,
  input  logic [AW-1:0]                      lin_off,
  input  logic [mtag_pkg::ADDR_FIELD_W-1:0]  tiled_base,
  input  logic [mtag_pkg::ADDR_FIELD_W-1:0]  linear_base,
  input  logic [mtag_pkg::BPP_FIELD_W-1:0]   pixel_bytes,
  output logic                               load_up,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [mtag_pkg::ADDR_FIELD_W-1:0]  tiled_address,
  output logic [mtag_pkg::ADDR_FIELD_W-1:0]  linear_address,
  output logic                               last,
  output logic                               format_error
);
  import mtag_pkg::*;

  logic [AW-1:0] til, lin;

  assign load_up = ~out_valid | ~out_stall;

  always_comb begin
    til = AW'(tiled_base) + AW'(tile_off * pixel_bytes);
    lin = AW'(linear_base) + AW'(lin_off * pixel_bytes);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_up) begin
      out_valid <= in_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_up && in_ctl.valid) begin
      tiled_address  <= in_ctl.err ? '0 : ADDR_FIELD_W'(til);
      linear_address <= in_ctl.err ? '0 : ADDR_FIELD_W'(lin);
      last           <= in_ctl.last & ~in_ctl.err;
      format_error   <= in_ctl.err;
    end
  end

endmodule

// ----- rtl/core/morton_tile_address_gen_top.sv -----
`timescale 1ns / 1ps

// Morton 8x8 tile address generator. Each accepted word (restart clears the
// walk first) gives one texel's tiled and linear byte addresses, walking
// texels in Z order inside a tile, tiles left to right and then upwards,
// with linear rows counted from the top. The three-stage pipeline
// (position counters, index multiplies, pixel-size scaling and base add)
// takes a new word every cycle unless the input is held;
// stalls on the output only hold the input once all three stages are full.
// Width and height are clamped to 8..MAX_DIM. A pixel size outside 1 to 4
// gives zero addresses with format_error set, and the walk holds.
// Configuration is meant to be written while nothing is in flight.
module morton_tile_address_gen_top #(
  parameter int ADDR_BITS = 32,
  parameter int MAX_DIM   = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [mtag_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [mtag_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               restart,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [mtag_pkg::ADDR_FIELD_W-1:0]  tiled_address,
  output logic [mtag_pkg::ADDR_FIELD_W-1:0]  linear_address,
  output logic                               last,
  output logic                               format_error
);
  import mtag_pkg::*;

  localparam int AW        = (ADDR_BITS < ADDR_FIELD_W) ? ADDR_BITS : ADDR_FIELD_W;
  localparam int DW        = $clog2(MAX_DIM + 1);
  localparam int CW        = (DW > DIM_FIELD_W) ? DW : DIM_FIELD_W;
  localparam int TILES_MAX = MAX_DIM / TILE_SIDE;
  localparam int CLW       = (TILES_MAX > 1) ? $clog2(TILES_MAX) : 1;
  localparam int CNT_W     = CLW + 1;

  logic [ADDR_FIELD_W-1:0] linear_base, tiled_base;
  logic [DIM_FIELD_W-1:0]  image_width, image_height;
  logic [BPP_FIELD_W-1:0]  pixel_bytes;

  logic [DW-1:0]         width_c, height_c;
  logic [CNT_W-1:0]      across, down;
  logic                  fmt_err;
  logic                  load1, load2, load3;
  mtag_ctl_t             ctl1, ctl2;
  logic [TEXEL_BITS-1:0] pos_texel;
  logic [CLW-1:0]        pos_column, pos_row;
  logic [AW-1:0]         tile_off, lin_off;

  always_ff @(posedge clk) begin
    if (rst) begin
      linear_base  <= '0;
      tiled_base   <= '0;
      image_width  <= DIM_FIELD_W'(TILE_SIDE);
      image_height <= DIM_FIELD_W'(TILE_SIDE);
      pixel_bytes  <= BPP_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_LINEAR_BASE:  linear_base  <= cfg_data[ADDR_FIELD_W-1:0];
        REG_TILED_BASE:   tiled_base   <= cfg_data[ADDR_FIELD_W-1:0];
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[DIM_FIELD_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[DIM_FIELD_W-1:0];
        REG_PIXEL_BYTES:  pixel_bytes  <= cfg_data[BPP_FIELD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (CW'(image_width) < CW'(TILE_SIDE)) begin
      width_c = DW'(TILE_SIDE);
    end else if (CW'(image_width) > CW'(MAX_DIM)) begin
      width_c = DW'(MAX_DIM);
    end else begin
      width_c = DW'(image_width);
    end
    if (CW'(image_height) < CW'(TILE_SIDE)) begin
      height_c = DW'(TILE_SIDE);
    end else if (CW'(image_height) > CW'(MAX_DIM)) begin
      height_c = DW'(MAX_DIM);
    end else begin
      height_c = DW'(image_height);
    end
    across  = CNT_W'(width_c >> TILE_SHIFT);
    down    = CNT_W'(height_c >> TILE_SHIFT);
    fmt_err = (pixel_bytes < BPP_MIN) || (pixel_bytes > BPP_MAX);
  end

  mtag_walker #(
    .CLW   (CLW),
    .CNT_W (CNT_W)
  ) u_walker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .restart    (restart),
    .in_stall   (in_stall),
    .fmt_err    (fmt_err),
    .across     (across),
    .down       (down),
    .load       (load1),
    .ctl        (ctl1),
    .pos_texel  (pos_texel),
    .pos_column (pos_column),
    .pos_row    (pos_row)
  );

  assign load1 = ~ctl1.valid | load2;

  mtag_index #(
    .AW    (AW),
    .CLW   (CLW),
    .CNT_W (CNT_W),
    .DW    (DW)
  ) u_index (
    .clk        (clk),
    .rst        (rst),
    .in_ctl     (ctl1),
    .pos_texel  (pos_texel),
    .pos_column (pos_column),
    .pos_row    (pos_row),
    .across     (across),
    .width_c    (width_c),
    .height_c   (height_c),
    .load       (load3),
    .load_up    (load2),
    .ctl        (ctl2),
    .tile_off   (tile_off),
    .lin_off    (lin_off)
  );

  mtag_scale #(
    .AW (AW)
  ) u_scale (
    .clk            (clk),
    .rst            (rst),
    .in_ctl         (ctl2),
    .tile_off       (tile_off),
    .lin_off        (lin_off),
    .tiled_base     (tiled_base),
    .linear_base    (linear_base),
    .pixel_bytes    (pixel_bytes),
    .load_up        (load3),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .tiled_address  (tiled_address),
    .linear_address (linear_address),
    .last           (last),
    .format_error   (format_error)
  );

endmodule

// ----- rtl/core/mtag_checker.sv -----
`timescale 1ns / 1ps

`include "morton_tile_address_gen_top_assert.svh"

module mtag_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic [mtag_pkg::ADDR_FIELD_W-1:0]  tiled_address,
  input logic [mtag_pkg::ADDR_FIELD_W-1:0]  linear_address,
  input logic                               last,
  input logic                               format_error
);

  // error words carry zero addresses and never mark the end
  `MTAG_ASSERT_NOW(a_err_zero, out_valid && format_error,
    tiled_address == '0 && linear_address == '0 && !last,
    "format error word with non-zero fields")

  // input only stalls with the output word waiting
  `MTAG_ASSERT_NOW(a_stall_needs_word, in_valid && in_stall, out_valid,
    "input stalled with an empty output register")

  `MTAG_ASSERT_NOW(a_stall_needs_back, in_valid && in_stall, out_stall,
    "input stalled while the output is free")

  `MTAG_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(tiled_address) && $stable(linear_address)
      && $stable(last) && $stable(format_error),
    "stalled output word changed")

endmodule

bind morton_tile_address_gen_top mtag_checker u_checker (.*);

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import mtag_pkg::*;

  localparam int DIM_LIMIT   = 1024;
  localparam int PLAN_ROWS   = 39;
  localparam int RAND_PHASES = 24;
  localparam int PHASE_WORDS = 70;
  localparam int HOLD_CYCLES = 64;
  localparam int QUIET_LIMIT = 2000;

  typedef struct packed {
    logic [ADDR_FIELD_W-1:0] tiled;
    logic [ADDR_FIELD_W-1:0] linear;
    logic                    last_texel;
    logic                    fmt_err;
  } addr_pair_t;

  typedef struct packed {
    logic                   is_write;
    logic [CFG_INDEX_W-1:0] reg_idx;
    logic [CFG_DATA_W-1:0]  reg_val;
    logic                   rs;
    logic [15:0]            reps;
    logic                   pinned;
    addr_pair_t             want;
  } plan_row_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic                    restart = 1'b0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [ADDR_FIELD_W-1:0] tiled_address;
  logic [ADDR_FIELD_W-1:0] linear_address;
  logic                    last;
  logic                    format_error;

  morton_tile_address_gen_top #(
    .ADDR_BITS(ADDR_FIELD_W),
    .MAX_DIM  (DIM_LIMIT)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .restart       (restart),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .tiled_address (tiled_address),
    .linear_address(linear_address),
    .last          (last),
    .format_error  (format_error)
  );

  // register mirror and walk position
  logic [ADDR_FIELD_W-1:0] cur_linear_base = '0;
  logic [ADDR_FIELD_W-1:0] cur_tiled_base = '0;
  logic [DIM_FIELD_W-1:0]  cur_width = 11'd8;
  logic [DIM_FIELD_W-1:0]  cur_height = 11'd8;
  logic [BPP_FIELD_W-1:0]  cur_bpp = BPP_RESET;
  logic [TEXEL_BITS-1:0]   walk_texel = '0;
  longint unsigned         walk_col = 0;
  longint unsigned         walk_trow = 0;

  addr_pair_t pending_pairs [$];
  logic       pin_en = 1'b0;
  addr_pair_t pin_word = '0;
  int         words_sent = 0;
  int         words_checked = 0;
  int         settings_written = 0;
  int         fails = 0;
  int         lasts_seen = 0;
  int         errs_seen = 0;
  int         quiet_cycles = 0;
  int         gap_pct = 0;
  int         stall_pct = 0;
  int         hold_reqs = 0;
  int         hold_served = 0;
  int         hold_left = 0;

  plan_row_t plan [PLAN_ROWS];

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic addr_pair_t walk_step(input logic rs);
    addr_pair_t            r;
    longint unsigned       w, h, across, down, idx, row_top;
    logic [TEXEL_BITS-1:0] t;
    logic [2:0]            x, y;
    r = '0;
    w = (cur_width < TILE_SIDE) ? TILE_SIDE : (cur_width > DIM_LIMIT) ? DIM_LIMIT : cur_width;
    h = (cur_height < TILE_SIDE) ? TILE_SIDE :
        (cur_height > DIM_LIMIT) ? DIM_LIMIT : cur_height;
    across = w / TILE_SIDE;
    down = h / TILE_SIDE;
    if (rs) begin
      walk_texel = '0;
      walk_col = 0;
      walk_trow = 0;
    end
    if (cur_bpp < BPP_MIN || cur_bpp > BPP_MAX) begin
      r.fmt_err = 1'b1;
      return r;
    end
    t = walk_texel;
    x = {t[4], t[2], t[0]};
    y = {t[5], t[3], t[1]};
    idx = (walk_trow * across + walk_col) * (TILE_SIDE * TILE_SIDE) + t;
    r.tiled = ADDR_FIELD_W'(cur_tiled_base + cur_bpp * idx);
    row_top = h - 1 - (walk_trow * TILE_SIDE + y);
    r.linear = ADDR_FIELD_W'(cur_linear_base +
                             cur_bpp * (row_top * w + walk_col * TILE_SIDE + x));
    r.last_texel = (t == TEXEL_LAST) && (walk_col == across - 1) && (walk_trow == down - 1);
    walk_texel = t + 1'b1;
    if (walk_texel == '0) begin
      walk_col++;
      if (walk_col >= across) begin
        walk_col = 0;
        walk_trow++;
        if (walk_trow >= down) walk_trow = 0;
      end
    end else begin
      if (walk_col >= across) walk_col = 0;
      if (walk_trow >= down) walk_trow = 0;
    end
    return r;
  endfunction

  function automatic plan_row_t set_row(input logic [CFG_INDEX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] val);
    plan_row_t p;
    p = '0;
    p.is_write = 1'b1;
    p.reg_idx = idx;
    p.reg_val = val;
    return p;
  endfunction

  function automatic plan_row_t walk_row(input logic rs, input int n);
    plan_row_t p;
    p = '0;
    p.rs = rs;
    p.reps = 16'(n);
    return p;
  endfunction

  function automatic plan_row_t pin_row(input logic rs, input logic [31:0] til,
                                        input logic [31:0] lin, input logic lst,
                                        input logic err);
    plan_row_t p;
    p = '0;
    p.rs = rs;
    p.reps = 16'd1;
    p.pinned = 1'b1;
    p.want = {til, lin, lst, err};
    return p;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_dim();
    logic [CFG_DATA_W-1:0] d;
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: d = $urandom_range(40, 8);
      6:                d = $urandom_range(7, 0);
      7:                d = $urandom_range(2047, 1025);
      8:                d = $urandom_range(1024, 8);
      default:          d = $urandom_range(1) ? 1024 : 8;
    endcase
    if ($urandom_range(1)) d[CFG_DATA_W-1:DIM_FIELD_W] = (CFG_DATA_W-DIM_FIELD_W)'($urandom);
    return d;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_base();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (words_checked != words_sent) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    wait_drained();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_LINEAR_BASE:  cur_linear_base = val;
      REG_TILED_BASE:   cur_tiled_base = val;
      REG_IMAGE_WIDTH:  cur_width = val[DIM_FIELD_W-1:0];
      REG_IMAGE_HEIGHT: cur_height = val[DIM_FIELD_W-1:0];
      REG_PIXEL_BYTES:  cur_bpp = val[BPP_FIELD_W-1:0];
      default: ;
    endcase
    settings_written++;
  endtask

  task automatic send_word(input logic rs, input logic pinned, input addr_pair_t want);
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    restart  <= rs;
    pin_en   <= pinned;
    pin_word <= want;
    do @(posedge clk); while (in_stall !== 1'b0);
    words_sent++;
  endtask

  // receiver: random stall, or a long hold-off on request
  always @(posedge clk) begin
    if (hold_reqs != hold_served) begin
      hold_served <= hold_reqs;
      hold_left   <= HOLD_CYCLES;
      out_stall   <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end
  end

  // word acceptance, prediction and result check
  always @(posedge clk) begin
    addr_pair_t got;
    addr_pair_t want;
    logic       took_in;
    logic       took_out;
    took_in  = !rst && in_valid && (in_stall === 1'b0);
    took_out = !rst && (out_valid === 1'b1) && !out_stall;
    if (took_in) begin
      want = walk_step(restart);
      if (pin_en) want = pin_word;
      pending_pairs.push_back(want);
    end
    if (took_out) begin
      got = {tiled_address, linear_address, last, format_error};
      if (got.last_texel === 1'b1) lasts_seen++;
      if (got.fmt_err === 1'b1) errs_seen++;
      if (pending_pairs.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("unexpected word: tiled %h linear %h last %b err %b",
                   got.tiled, got.linear, got.last_texel, got.fmt_err);
      end else begin
        want = pending_pairs.pop_front();
        if (got.tiled !== want.tiled || got.linear !== want.linear ||
            got.last_texel !== want.last_texel || got.fmt_err !== want.fmt_err) begin
          fails++;
          if (fails <= 10) begin
            $display("mismatch at word %0d: expected tiled %h linear %h last %b err %b",
                     words_checked, want.tiled, want.linear, want.last_texel, want.fmt_err);
            $display("  got tiled %h linear %h last %b err %b",
                     got.tiled, got.linear, got.last_texel, got.fmt_err);
          end
        end
      end
      words_checked++;
    end
    quiet_cycles <= (rst || took_in || took_out) ? 0 : quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  initial begin
    plan = '{
      pin_row(1'b0, 32'h0, 32'd224, 1'b0, 1'b0),
      walk_row(1'b0, 62),
      pin_row(1'b0, 32'd252, 32'd28, 1'b1, 1'b0),
      pin_row(1'b0, 32'h0, 32'd224, 1'b0, 1'b0),
      walk_row(1'b1, 1),
      walk_row(1'b0, 4),
      set_row(REG_PIXEL_BYTES, 32'd0),
      pin_row(1'b0, 32'h0, 32'h0, 1'b0, 1'b1),
      pin_row(1'b1, 32'h0, 32'h0, 1'b0, 1'b1),
      set_row(REG_PIXEL_BYTES, 32'd7),
      pin_row(1'b0, 32'h0, 32'h0, 1'b0, 1'b1),
      set_row(REG_PIXEL_BYTES, 32'd1),
      pin_row(1'b0, 32'h0, 32'd56, 1'b0, 1'b0),
      set_row(REG_PIXEL_BYTES, 32'd2),
      walk_row(1'b0, 3),
      set_row(REG_PIXEL_BYTES, 32'd3),
      walk_row(1'b0, 3),
      set_row(REG_LINEAR_BASE, 32'hFFFF_FFFF),
      set_row(REG_TILED_BASE, 32'hFFFF_FFFF),
      set_row(REG_IMAGE_WIDTH, 32'd1024),
      set_row(REG_IMAGE_HEIGHT, 32'd1024),
      set_row(REG_PIXEL_BYTES, 32'd4),
      pin_row(1'b1, 32'hFFFF_FFFF, 32'h003F_EFFF, 1'b0, 1'b0),
      walk_row(1'b0, 4),
      set_row(REG_IMAGE_WIDTH, 32'd0),
      set_row(REG_IMAGE_HEIGHT, 32'd2047),
      walk_row(1'b1, 2),
      set_row(REG_IMAGE_WIDTH, 32'd2047),
      set_row(REG_IMAGE_HEIGHT, 32'd0),
      walk_row(1'b1, 2),
      set_row(REG_LINEAR_BASE, 32'h0),
      set_row(REG_TILED_BASE, 32'h0),
      set_row(REG_IMAGE_WIDTH, 32'd16),
      set_row(REG_IMAGE_HEIGHT, 32'd16),
      walk_row(1'b1, 1),
      walk_row(1'b0, 191),
      // shrink so the walk sits past the last column and row
      set_row(REG_IMAGE_WIDTH, 32'd8),
      set_row(REG_IMAGE_HEIGHT, 32'd8),
      walk_row(1'b0, 3)
    };

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < PLAN_ROWS; r++) begin
      if (plan[r].is_write) begin
        write_reg(plan[r].reg_idx, plan[r].reg_val);
      end else begin
        for (int k = 0; k < plan[r].reps; k++)
          send_word(plan[r].rs, plan[r].pinned, plan[r].want);
      end
    end

    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      if (phase == 0) begin
        write_reg(REG_LINEAR_BASE, '0);
        write_reg(REG_TILED_BASE, '0);
        write_reg(REG_IMAGE_WIDTH, 32'd8);
        write_reg(REG_IMAGE_HEIGHT, 32'd8);
        write_reg(REG_PIXEL_BYTES, 32'd1);
      end else if (phase == 1) begin
        write_reg(REG_LINEAR_BASE, '1);
        write_reg(REG_TILED_BASE, '1);
        write_reg(REG_IMAGE_WIDTH, 32'd1024);
        write_reg(REG_IMAGE_HEIGHT, 32'd1024);
        write_reg(REG_PIXEL_BYTES, 32'd4);
      end else begin
        write_reg(REG_LINEAR_BASE, pick_base());
        write_reg(REG_TILED_BASE, pick_base());
        write_reg(REG_IMAGE_WIDTH, pick_dim());
        write_reg(REG_IMAGE_HEIGHT, pick_dim());
        if ($urandom_range(7) < 6)
          write_reg(REG_PIXEL_BYTES, ($urandom & ~32'h7) | $urandom_range(4, 1));
        else
          write_reg(REG_PIXEL_BYTES, ($urandom & ~32'h7) | ($urandom_range(3, 0) * 32'd5 % 8));
      end
      case (phase % 4)
        0:       begin gap_pct = 0;  stall_pct <= 0;  end
        1:       begin gap_pct = 49; stall_pct <= 0;  end
        2:       begin gap_pct = 0;  stall_pct <= 49; end
        default: begin gap_pct = 19; stall_pct <= 19; end
      endcase
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (phase == 4 && n == 10) hold_reqs <= hold_reqs + 1;
        if (phase == 10 && n == 40) wait_drained();
        send_word($urandom_range(63) == 0, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (pending_pairs.size() != 0) begin
      fails++;
      $display("%0d expected words never arrived", pending_pairs.size());
    end
    $display("%0d words checked, %0d register writes, %0d last texels, %0d format errors",
             words_checked, settings_written, lasts_seen, errs_seen);
    $display("idle mixes: none, sender, receiver, both; one long output hold-off, one mid-run drain");
    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
